// ===== design/ps2kbd_pkg.sv =====
package ps2kbd_pkg;

   // Bytes from the keyboard.
   localparam logic [7:0] SC_BACKSPACE   = 8'h0E;
   localparam logic [7:0] SC_TAB         = 8'h0F;
   localparam logic [7:0] SC_ENTER       = 8'h1C;
   localparam logic [7:0] SC_F1          = 8'h3B;
   localparam logic [7:0] SC_F11         = 8'h57;
   localparam logic [7:0] SC_LSHIFT_MAKE = 8'h2A;
   localparam logic [7:0] SC_RSHIFT_MAKE = 8'h36;
   localparam logic [7:0] SC_LSHIFT_BRK  = 8'hAA;
   localparam logic [7:0] SC_RSHIFT_BRK  = 8'hB6;
   localparam logic [7:0] SC_CAPS_LOCK   = 8'h3A;
   localparam logic [7:0] SC_NUM_LOCK    = 8'h45;
   localparam logic [7:0] SC_SCROLL_LOCK = 8'h46;
   localparam logic [7:0] KBD_ACK        = 8'hFA;
   localparam logic [7:0] KBD_RESEND     = 8'hFE;

   // Command byte sent to the keyboard.
   localparam logic [7:0] LED_CMD        = 8'hED;

   // Lock bit masks.
   localparam logic [2:0] LOCK_SCROLL    = 3'b001;
   localparam logic [2:0] LOCK_NUM       = 3'b010;
   localparam logic [2:0] LOCK_CAPS      = 3'b100;

   localparam logic [6:0] ASCII_UPPER_A  = 7'h41;
   localparam logic [6:0] ASCII_UPPER_Z  = 7'h5A;
   localparam logic [6:0] ASCII_CASE_BIT = 7'h20;

   typedef enum logic [2:0] {
      KEY_EV_NONE      = 3'd0,
      KEY_EV_BACKSPACE = 3'd1,
      KEY_EV_TAB       = 3'd2,
      KEY_EV_ENTER     = 3'd3,
      KEY_EV_SHIFT_F1  = 3'd4,
      KEY_EV_F11       = 3'd5
   } key_event_type;

   typedef struct packed {
      logic restart;
      logic lock_push;
      logic pop;
   } queue_ctl_type;

   typedef struct packed {
      logic       nonempty;
      logic [7:0] head_byte;
   } queue_status_type;

   // Set 1 make code to character; zero where the key prints nothing.
   function automatic logic [6:0] key_char(input logic [6:0] code, input logic shifted);
      logic [6:0] c;
      case (code)
         7'h02: c = 7'h31;
         7'h03: c = 7'h32;
         7'h04: c = 7'h33;
         7'h05: c = 7'h34;
         7'h06: c = 7'h35;
         7'h07: c = 7'h36;
         7'h08: c = 7'h37;
         7'h09: c = 7'h38;
         7'h0A: c = 7'h39;
         7'h0B: c = 7'h30;
         7'h0C: c = 7'h2D;
         7'h0D: c = 7'h5E;
         7'h10: c = 7'h51;
         7'h11: c = 7'h57;
         7'h12: c = 7'h45;
         7'h13: c = 7'h52;
         7'h14: c = 7'h54;
         7'h15: c = 7'h59;
         7'h16: c = 7'h55;
         7'h17: c = 7'h49;
         7'h18: c = 7'h4F;
         7'h19: c = 7'h50;
         7'h1A: c = 7'h40;
         7'h1B: c = 7'h5B;
         7'h1E: c = 7'h41;
         7'h1F: c = 7'h53;
         7'h20: c = 7'h44;
         7'h21: c = 7'h46;
         7'h22: c = 7'h47;
         7'h23: c = 7'h48;
         7'h24: c = 7'h4A;
         7'h25: c = 7'h4B;
         7'h26: c = 7'h4C;
         7'h27: c = 7'h3B;
         7'h28: c = 7'h3A;
         7'h2B: c = 7'h5D;
         7'h2C: c = 7'h5A;
         7'h2D: c = 7'h58;
         7'h2E: c = 7'h43;
         7'h2F: c = 7'h56;
         7'h30: c = 7'h42;
         7'h31: c = 7'h4E;
         7'h32: c = 7'h4D;
         7'h33: c = 7'h2C;
         7'h34: c = 7'h2E;
         7'h35: c = 7'h2F;
         7'h37: c = 7'h2A;
         7'h39: c = 7'h20;
         7'h47: c = 7'h37;
         7'h48: c = 7'h38;
         7'h49: c = 7'h39;
         7'h4A: c = 7'h2D;
         7'h4B: c = 7'h34;
         7'h4C: c = 7'h35;
         7'h4D: c = 7'h36;
         7'h4E: c = 7'h2B;
         7'h4F: c = 7'h31;
         7'h50: c = 7'h32;
         7'h51: c = 7'h33;
         7'h52: c = 7'h30;
         7'h53: c = 7'h2E;
         7'h73: c = 7'h5C;
         7'h7D: c = 7'h5C;
         default: c = 7'h00;
      endcase
      if (shifted) begin
         case (code)
            7'h02: c = 7'h21;
            7'h03: c = 7'h22;
            7'h04: c = 7'h23;
            7'h05: c = 7'h24;
            7'h06: c = 7'h25;
            7'h07: c = 7'h26;
            7'h08: c = 7'h27;
            7'h09: c = 7'h28;
            7'h0A: c = 7'h29;
            7'h0B: c = 7'h7E;
            7'h0C: c = 7'h3D;
            7'h0D: c = 7'h7E;
            7'h1A: c = 7'h60;
            7'h1B: c = 7'h7B;
            7'h27: c = 7'h2B;
            7'h28: c = 7'h2A;
            7'h2B: c = 7'h7D;
            7'h33: c = 7'h3C;
            7'h34: c = 7'h3E;
            7'h35: c = 7'h3F;
            7'h73: c = 7'h5F;
            7'h7D: c = 7'h7C;
            default: c = c;
         endcase
      end
      return c;
   endfunction

endpackage

// ===== design/ps2kbd_req_if.sv =====
interface ps2kbd_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] scan_byte;

   modport source (output valid, output req_type, output scan_byte, input ready);
   modport sink   (input valid, input req_type, input scan_byte, output ready);
endinterface

// ===== design/ps2kbd_rsp_if.sv =====
interface ps2kbd_rsp_if;
   logic       valid;
   logic       ready;
   logic       char_valid;
   logic [6:0] char_code;
   logic [2:0] key_event;
   logic       send_valid;
   logic [7:0] send_byte;
   logic [2:0] lock_bits;

   modport source (output valid, output char_valid, output char_code, output key_event,
                   output send_valid, output send_byte, output lock_bits, input ready);
   modport sink   (input valid, input char_valid, input char_code, input key_event,
                   input send_valid, input send_byte, input lock_bits, output ready);
endinterface

// ===== design/ps2kbd_cmd_queue.sv =====
module ps2kbd_cmd_queue #(
   parameter int DEPTH = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ps2kbd_pkg::queue_ctl_type    ctl,
   input  logic [2:0]                   lock_bits,
   output ps2kbd_pkg::queue_status_type status
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [IW-1:0] RESTART_TAIL = IW'(2 % DEPTH);
   localparam logic [CW-1:0] RESTART_COUNT = CW'(2);

   logic [7:0]    mem_ff [DEPTH];
   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] tail_next;
   logic [CW-1:0] count_mid;
   logic          push_first, push_second;

   function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] ptr);
      return (ptr == IW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   // A lock key pushes the LED command and then the lock bits; each byte
   // is dropped on its own when it does not fit.
   always_comb begin
      push_first  = ctl.lock_push && (count_ff < CW'(DEPTH));
      push_second = ctl.lock_push && (count_ff < CW'(DEPTH - 1));
      tail_next   = wrap_inc(tail_ff);
      count_mid   = count_ff + CW'(push_first) + CW'(push_second);
      count_in    = count_mid - CW'(ctl.pop);
      head_in     = ctl.pop ? wrap_inc(head_ff) : head_ff;
      if (push_second) begin
         tail_in = wrap_inc(tail_next);
      end else if (push_first) begin
         tail_in = tail_next;
      end else begin
         tail_in = tail_ff;
      end
   end

   // When the queue is empty the head can only be a freshly pushed LED command.
   assign status.nonempty  = (count_mid != '0);
   assign status.head_byte = (count_ff == '0) ? ps2kbd_pkg::LED_CMD : mem_ff[head_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         tail_ff   <= RESTART_TAIL;
         count_ff  <= RESTART_COUNT;
         mem_ff[0] <= ps2kbd_pkg::LED_CMD;
         mem_ff[1] <= 8'h00;
      end else if (ctl.restart) begin
         head_ff   <= '0;
         tail_ff   <= RESTART_TAIL;
         count_ff  <= RESTART_COUNT;
         mem_ff[0] <= ps2kbd_pkg::LED_CMD;
         mem_ff[1] <= {5'b00000, lock_bits};
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         if (push_first) begin
            mem_ff[tail_ff] <= ps2kbd_pkg::LED_CMD;
         end
         if (push_second) begin
            mem_ff[tail_next] <= {5'b00000, lock_bits};
         end
      end
   end

endmodule

// ===== design/ps2_keyboard_scancode_decoder.sv =====
// Channel   Dir  Handshake      Payload
// req_bus   in   valid/ready    req_type, scan_byte
// rsp_bus   out  valid/ready    char_valid, char_code, key_event, send_valid,
//                               send_byte, lock_bits
// csr       in   csr_wr_en      csr_wr_data (initial lock bits)
//
// One request per cycle while rsp_bus drains; its response appears in the cycle
// after acceptance. The decode, lock update and command queue step all settle then.
// The output register holds a response until taken; req_bus.ready stays high
// while the register is empty or being drained in the same cycle.
// Synchronous reset clears all lock and shift state and preloads the LED command.
module ps2_keyboard_scancode_decoder #(
   parameter int CMD_QUEUE_DEPTH = 8
) (
   input  logic               clock,
   input  logic               reset,
   ps2kbd_req_if.sink         req_bus,
   ps2kbd_rsp_if.source       rsp_bus,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_wr_data
);

   logic [1:0] shift_ff, shift_in;
   logic [2:0] lock_ff, lock_in;
   logic       awaiting_ff, awaiting_in;
   logic [7:0] last_sent_ff, last_sent_in;

   logic       rsp_valid_ff;
   logic       rsp_char_valid_ff;
   logic [6:0] rsp_char_code_ff;
   logic [2:0] rsp_key_event_ff;
   logic       rsp_send_valid_ff;
   logic [7:0] rsp_send_byte_ff;
   logic [2:0] rsp_lock_bits_ff;

   logic       req_fire;
   logic       is_byte;
   logic [7:0] b;
   logic [6:0] ch_raw, ch;
   logic       shifted, is_upper;
   logic       lock_key;
   logic [2:0] lock_mask;
   logic       awaiting_mid;
   logic       resend;
   logic       send_valid;
   logic [7:0] send_byte;
   ps2kbd_pkg::key_event_type      ev;
   ps2kbd_pkg::queue_ctl_type      q_ctl;
   ps2kbd_pkg::queue_status_type   q_status;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign is_byte       = req_bus.req_type;
   assign b             = req_bus.scan_byte;

   always_comb begin
      shifted  = (shift_ff != 2'b00);
      ch_raw   = (is_byte && !b[7]) ? ps2kbd_pkg::key_char(b[6:0], shifted) : 7'h00;
      is_upper = (ch_raw >= ps2kbd_pkg::ASCII_UPPER_A) && (ch_raw <= ps2kbd_pkg::ASCII_UPPER_Z);
      // Letters print lowercase unless caps lock and shift disagree.
      if (is_upper && ((lock_ff[2]) == shifted)) begin
         ch = ch_raw + ps2kbd_pkg::ASCII_CASE_BIT;
      end else begin
         ch = ch_raw;
      end

      ev = ps2kbd_pkg::KEY_EV_NONE;
      if (is_byte) begin
         if (b == ps2kbd_pkg::SC_BACKSPACE) begin
            ev = ps2kbd_pkg::KEY_EV_BACKSPACE;
         end else if (b == ps2kbd_pkg::SC_TAB) begin
            ev = ps2kbd_pkg::KEY_EV_TAB;
         end else if (b == ps2kbd_pkg::SC_ENTER) begin
            ev = ps2kbd_pkg::KEY_EV_ENTER;
         end else if (b == ps2kbd_pkg::SC_F1 && shifted) begin
            ev = ps2kbd_pkg::KEY_EV_SHIFT_F1;
         end else if (b == ps2kbd_pkg::SC_F11) begin
            ev = ps2kbd_pkg::KEY_EV_F11;
         end
      end

      shift_in = shift_ff;
      if (is_byte) begin
         if (b == ps2kbd_pkg::SC_LSHIFT_MAKE) shift_in[0] = 1'b1;
         if (b == ps2kbd_pkg::SC_RSHIFT_MAKE) shift_in[1] = 1'b1;
         if (b == ps2kbd_pkg::SC_LSHIFT_BRK)  shift_in[0] = 1'b0;
         if (b == ps2kbd_pkg::SC_RSHIFT_BRK)  shift_in[1] = 1'b0;
      end

      case (b)
         ps2kbd_pkg::SC_CAPS_LOCK:   lock_mask = ps2kbd_pkg::LOCK_CAPS;
         ps2kbd_pkg::SC_NUM_LOCK:    lock_mask = ps2kbd_pkg::LOCK_NUM;
         ps2kbd_pkg::SC_SCROLL_LOCK: lock_mask = ps2kbd_pkg::LOCK_SCROLL;
         default:                    lock_mask = 3'b000;
      endcase
      lock_key = is_byte && (lock_mask != 3'b000);
      lock_in  = lock_ff ^ (is_byte ? lock_mask : 3'b000);

      // A resend repeats the last byte only while its acknowledge is pending.
      awaiting_mid = awaiting_ff && !(is_byte && b == ps2kbd_pkg::KBD_ACK);
      resend       = is_byte && (b == ps2kbd_pkg::KBD_RESEND) && awaiting_ff;

      q_ctl.restart   = csr_wr_en;
      q_ctl.lock_push = req_fire && lock_key;
      q_ctl.pop       = req_fire && !resend && !awaiting_mid && q_status.nonempty;

      send_valid = resend || q_ctl.pop;
      if (resend) begin
         send_byte = last_sent_ff;
      end else if (q_ctl.pop) begin
         send_byte = q_status.head_byte;
      end else begin
         send_byte = 8'h00;
      end
      last_sent_in = q_ctl.pop ? q_status.head_byte : last_sent_ff;
      awaiting_in  = q_ctl.pop ? 1'b1 : awaiting_mid;
   end

   ps2kbd_cmd_queue #(
      .DEPTH (CMD_QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .ctl       (q_ctl),
      .lock_bits (csr_wr_en ? csr_wr_data : lock_in),
      .status    (q_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= 2'b00;
         lock_ff      <= 3'b000;
         awaiting_ff  <= 1'b0;
         last_sent_ff <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            lock_ff     <= csr_wr_data;
            awaiting_ff <= 1'b0;
         end else if (req_fire) begin
            shift_ff     <= shift_in;
            lock_ff      <= lock_in;
            awaiting_ff  <= awaiting_in;
            last_sent_ff <= last_sent_in;
         end
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_char_valid_ff <= (ch != 7'h00);
         rsp_char_code_ff  <= ch;
         rsp_key_event_ff  <= ev;
         rsp_send_valid_ff <= send_valid;
         rsp_send_byte_ff  <= send_byte;
         rsp_lock_bits_ff  <= lock_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.char_valid = rsp_char_valid_ff;
   assign rsp_bus.char_code  = rsp_char_code_ff;
   assign rsp_bus.key_event  = rsp_key_event_ff;
   assign rsp_bus.send_valid = rsp_send_valid_ff;
   assign rsp_bus.send_byte  = rsp_send_byte_ff;
   assign rsp_bus.lock_bits  = rsp_lock_bits_ff;

   // No queued byte may go out while an earlier one still waits for its acknowledge.
   a_no_pop_while_pending: assert property (@(posedge clock) disable iff (reset)
      req_fire && awaiting_ff && !(is_byte && b == ps2kbd_pkg::KBD_ACK) |-> !q_ctl.pop)
      else $error("queue popped while an acknowledge was pending");

   // A response flags a character exactly when its code is nonzero.
   a_char_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_char_valid_ff == (rsp_char_code_ff != 7'h00)))
      else $error("char_valid disagrees with char_code");

   // A response that sends nothing carries a zero send byte.
   a_send_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_send_valid_ff |-> (rsp_send_byte_ff == 8'h00))
      else $error("send_byte set without send_valid");

   // Lock bits move only on a lock key or a register write.
   a_lock_stable: assert property (@(posedge clock) disable iff (reset)
      !csr_wr_en && !(req_fire && lock_key) |=> $stable(lock_ff))
      else $error("lock bits changed without a lock key or register write");

endmodule
